// File: hdl/cra_pkg.sv
// Shared types, widths and the quarter-wave sine lookup for the point rotation block.
// No dependencies; every other file in hdl imports this package.
`timescale 1ns / 1ps

package cra_pkg;

    localparam int COORD_BITS     = 24;
    localparam int SINE_FRAC_BITS = 15;
    localparam int ANGLE_BITS     = 8;
    localparam int HEADING_BITS   = 8;
    localparam int CENTER_BITS    = 20;
    localparam int CFG_INDEX_BITS = 8;
    localparam int TABLE_FRAC     = 15;
    localparam int TABLE_DEPTH    = 64;
    localparam int TABLE_ONE      = 1 << TABLE_FRAC;

    // Table entry width and quarter-wave index width (0..64 inclusive)
    localparam int TABLE_W = TABLE_FRAC + 1;
    localparam int QIDX_W  = ANGLE_BITS - 1;

    // Rescaling of the Q1.15 table to the working fraction
    localparam int SINE_UP     = (SINE_FRAC_BITS >= TABLE_FRAC) ? SINE_FRAC_BITS - TABLE_FRAC : 0;
    localparam int SINE_DN     = (SINE_FRAC_BITS < TABLE_FRAC) ? TABLE_FRAC - SINE_FRAC_BITS : 0;
    localparam int SINE_RND    = (1 << SINE_DN) >> 1;
    localparam int TRIG_WORK_W = (SINE_FRAC_BITS >= TABLE_FRAC) ? SINE_FRAC_BITS + 1
                                                                : TABLE_FRAC + 2;
    localparam int SINE_W      = SINE_FRAC_BITS + 2;

    // Datapath widths
    localparam int DIFF_W = ((COORD_BITS > CENTER_BITS) ? COORD_BITS : CENTER_BITS + 1) + 1;
    localparam int PROD_W = DIFF_W + SINE_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int RES_W  = SUM_W;

    localparam logic [ANGLE_BITS-1:0] ANGLE_ZERO          = ANGLE_BITS'(0);
    localparam logic [ANGLE_BITS-1:0] ANGLE_QUARTER       = ANGLE_BITS'(1 << (ANGLE_BITS - 2));
    localparam logic [ANGLE_BITS-1:0] ANGLE_HALF          = ANGLE_BITS'(2 << (ANGLE_BITS - 2));
    localparam logic [ANGLE_BITS-1:0] ANGLE_THREE_QUARTER = ANGLE_BITS'(3 << (ANGLE_BITS - 2));

    localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_X = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_Y = CFG_INDEX_BITS'(1);

    localparam logic [CENTER_BITS-1:0] CENTER_RESET = CENTER_BITS'(50000);

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // round(32768 * sin(k * pi / 128)), k = 0..63
    localparam logic [TABLE_W-1:0] QUARTER_SINE [TABLE_DEPTH] = '{
        16'd0,     16'd804,   16'd1608,  16'd2411,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
        16'd6393,  16'd7180,  16'd7962,  16'd8740,  16'd9512,  16'd10279, 16'd11039, 16'd11793,
        16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447, 16'd16151, 16'd16846, 16'd17531,
        16'd18205, 16'd18868, 16'd19520, 16'd20160, 16'd20788, 16'd21403, 16'd22006, 16'd22595,
        16'd23170, 16'd23732, 16'd24279, 16'd24812, 16'd25330, 16'd25833, 16'd26320, 16'd26791,
        16'd27246, 16'd27684, 16'd28106, 16'd28511, 16'd28899, 16'd29269, 16'd29622, 16'd29957,
        16'd30274, 16'd30572, 16'd30853, 16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972,
        16'd32138, 16'd32286, 16'd32413, 16'd32522, 16'd32610, 16'd32679, 16'd32729, 16'd32758
    };

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic [ANGLE_BITS-1:0]        angle;
        logic [HEADING_BITS-1:0]      heading;
    } point_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] rotated_x;
        logic signed [COORD_BITS-1:0] rotated_y;
        logic [HEADING_BITS-1:0]      new_heading;
        logic                         saturated;
    } result_t;

    // Products and exact quarter-turn forms passed to the final stage
    typedef struct packed {
        logic signed [PROD_W-1:0] prod_xc;
        logic signed [PROD_W-1:0] prod_ys;
        logic signed [PROD_W-1:0] prod_xs;
        logic signed [PROD_W-1:0] prod_yc;
        logic                     special;
        logic signed [RES_W-1:0]  special_x;
        logic signed [RES_W-1:0]  special_y;
        logic [HEADING_BITS-1:0]  new_heading;
    } prod_t;

    // Full-turn sine at SINE_FRAC_BITS fraction bits
    function automatic logic signed [SINE_W-1:0] sine_of(input logic [ANGLE_BITS-1:0] a);
        logic [1:0]             quad;
        logic [QIDX_W-1:0]      idx;
        logic [TRIG_WORK_W-1:0] mag;
        logic signed [SINE_W-1:0] scaled;
        quad = a[ANGLE_BITS-1 -: 2];
        if (quad[0])
        begin
            idx = QIDX_W'(TABLE_DEPTH) - QIDX_W'(a[ANGLE_BITS-3:0]);
        end
        else
        begin
            idx = QIDX_W'(a[ANGLE_BITS-3:0]);
        end
        // index 64 stands for exactly one
        if (idx[QIDX_W-1])
        begin
            mag = TRIG_WORK_W'(TABLE_ONE);
        end
        else
        begin
            mag = TRIG_WORK_W'(QUARTER_SINE[idx[QIDX_W-2:0]]);
        end
        if (SINE_FRAC_BITS >= TABLE_FRAC)
        begin
            mag = mag << SINE_UP;
        end
        else
        begin
            mag = (mag + TRIG_WORK_W'(SINE_RND)) >> SINE_DN;
        end
        scaled = SINE_W'(mag);
        return quad[1] ? -scaled : scaled;
    endfunction

endpackage

// File: hdl/cra_product_stage.sv
// First datapath stage: offsets from the centre, sine/cosine lookup, the four products
// and the exact quarter-turn forms. Depends on cra_pkg.
`timescale 1ns / 1ps

module cra_product_stage
    import cra_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  point_t                 in_item,
    input  logic [CENTER_BITS-1:0] center_x,
    input  logic [CENTER_BITS-1:0] center_y,
    input  logic                   ready_down,
    output logic                   ready_up,
    output logic                   out_valid,
    output prod_t                  out_data
);

    logic                     valid_reg;
    logic                     valid_next;
    prod_t                    data_reg;
    prod_t                    data_next;

    logic signed [DIFF_W-1:0] x_d;
    logic signed [DIFF_W-1:0] y_d;
    logic signed [DIFF_W-1:0] cx_d;
    logic signed [DIFF_W-1:0] cy_d;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [ANGLE_BITS-1:0]    cos_angle;
    logic signed [SINE_W-1:0] sin_v;
    logic signed [SINE_W-1:0] cos_v;
    logic signed [RES_W-1:0]  xr;
    logic signed [RES_W-1:0]  yr;
    logic signed [RES_W-1:0]  cxr;
    logic signed [RES_W-1:0]  cyr;

    always_comb
    begin
        x_d  = DIFF_W'(in_item.point_x);
        y_d  = DIFF_W'(in_item.point_y);
        cx_d = DIFF_W'($signed({1'b0, center_x}));
        cy_d = DIFF_W'($signed({1'b0, center_y}));
        dx   = x_d - cx_d;
        dy   = y_d - cy_d;

        cos_angle = in_item.angle + ANGLE_QUARTER;
        sin_v     = sine_of(in_item.angle);
        cos_v     = sine_of(cos_angle);

        xr  = RES_W'(in_item.point_x);
        yr  = RES_W'(in_item.point_y);
        cxr = RES_W'($signed({1'b0, center_x}));
        cyr = RES_W'($signed({1'b0, center_y}));

        data_next.prod_xc     = PROD_W'(dx) * PROD_W'(cos_v);
        data_next.prod_ys     = PROD_W'(dy) * PROD_W'(sin_v);
        data_next.prod_xs     = PROD_W'(dx) * PROD_W'(sin_v);
        data_next.prod_yc     = PROD_W'(dy) * PROD_W'(cos_v);
        data_next.new_heading = in_item.heading + in_item.angle;

        // zero, quarter, half and three-quarter turns bypass the products
        data_next.special = 1'b1;
        case (in_item.angle)
            ANGLE_ZERO:
            begin
                data_next.special_x = xr;
                data_next.special_y = yr;
            end
            ANGLE_QUARTER:
            begin
                data_next.special_x = cyr - yr + cxr;
                data_next.special_y = xr - cxr + cyr;
            end
            ANGLE_HALF:
            begin
                data_next.special_x = cxr - xr + cxr;
                data_next.special_y = cyr - yr + cyr;
            end
            ANGLE_THREE_QUARTER:
            begin
                data_next.special_x = yr - cyr + cxr;
                data_next.special_y = cxr - xr + cyr;
            end
            default:
            begin
                data_next.special   = 1'b0;
                data_next.special_x = '0;
                data_next.special_y = '0;
            end
        endcase
    end

    assign ready_up   = !valid_reg || ready_down;
    assign valid_next = ready_up ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: hdl/cra_result_stage.sv
// Final datapath stage: sums, truncation toward zero, centre offset, saturation,
// and the output register. Depends on cra_pkg.
`timescale 1ns / 1ps

module cra_result_stage
    import cra_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  prod_t                  in_data,
    input  logic [CENTER_BITS-1:0] center_x,
    input  logic [CENTER_BITS-1:0] center_y,
    input  logic                   stall,
    output logic                   ready_up,
    output logic                   out_valid,
    output result_t                out_item
);

    logic                    valid_reg;
    logic                    valid_next;
    result_t                 result_reg;
    result_t                 result_next;

    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [SUM_W-1:0] bias_x;
    logic signed [SUM_W-1:0] bias_y;
    logic signed [SUM_W-1:0] biased_x;
    logic signed [SUM_W-1:0] biased_y;
    logic signed [SUM_W-1:0] trunc_x;
    logic signed [SUM_W-1:0] trunc_y;
    logic signed [RES_W-1:0] cxr;
    logic signed [RES_W-1:0] cyr;
    logic signed [RES_W-1:0] full_x;
    logic signed [RES_W-1:0] full_y;
    logic signed [RES_W-1:0] max_r;
    logic signed [RES_W-1:0] min_r;
    logic                    high_x;
    logic                    low_x;
    logic                    high_y;
    logic                    low_y;

    always_comb
    begin
        sum_x = SUM_W'(in_data.prod_xc) - SUM_W'(in_data.prod_ys);
        sum_y = SUM_W'(in_data.prod_xs) + SUM_W'(in_data.prod_yc);

        // bias negative sums so the arithmetic shift truncates toward zero
        bias_x   = sum_x[SUM_W-1] ? SUM_W'((1 << SINE_FRAC_BITS) - 1) : '0;
        bias_y   = sum_y[SUM_W-1] ? SUM_W'((1 << SINE_FRAC_BITS) - 1) : '0;
        biased_x = sum_x + bias_x;
        biased_y = sum_y + bias_y;
        trunc_x  = biased_x >>> SINE_FRAC_BITS;
        trunc_y  = biased_y >>> SINE_FRAC_BITS;

        cxr = RES_W'($signed({1'b0, center_x}));
        cyr = RES_W'($signed({1'b0, center_y}));

        full_x = in_data.special ? in_data.special_x : cxr + trunc_x;
        full_y = in_data.special ? in_data.special_y : cyr + trunc_y;

        max_r  = RES_W'(COORD_MAX);
        min_r  = RES_W'(COORD_MIN);
        high_x = full_x > max_r;
        low_x  = full_x < min_r;
        high_y = full_y > max_r;
        low_y  = full_y < min_r;

        result_next.rotated_x   = high_x ? COORD_MAX : (low_x ? COORD_MIN : COORD_BITS'(full_x));
        result_next.rotated_y   = high_y ? COORD_MAX : (low_y ? COORD_MIN : COORD_BITS'(full_y));
        result_next.new_heading = in_data.new_heading;
        result_next.saturated   = high_x || low_x || high_y || low_y;
    end

    assign ready_up   = !valid_reg || !stall;
    assign valid_next = ready_up ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && in_valid)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = result_reg;

endmodule

// File: hdl/coordinate_rotate_about_center.sv
// Top level: rotates a point about the configured centre and advances its heading.
// Path: an accepted point passes through the input, product and result registers in order.
// Throughput: one transaction per cycle while result_stall is low; each register loads when empty or freed.
// Reset: asynchronous, active low; empties the pipeline and sets both centre registers to 50000.
// Depends on cra_pkg, cra_product_stage and cra_result_stage.
`timescale 1ns / 1ps

module coordinate_rotate_about_center
    import cra_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      point_valid,
    output logic                      point_stall,
    input  point_t                    point,
    output logic                      result_valid,
    input  logic                      result_stall,
    output result_t                   result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CENTER_BITS-1:0]    cfg_data
);

    logic [CENTER_BITS-1:0] center_x_reg;
    logic [CENTER_BITS-1:0] center_y_reg;

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    point_t                 s1_item_reg;
    logic                   s1_ready;

    logic                   prod_ready;
    logic                   prod_valid;
    prod_t                  prod_data;
    logic                   res_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= CENTER_RESET;
            center_y_reg <= CENTER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // drop writes to indexes past the register list
            if (cfg_index == CFG_CENTER_X)
            begin
                center_x_reg <= cfg_data;
            end
            else if (cfg_index == CFG_CENTER_Y)
            begin
                center_y_reg <= cfg_data;
            end
        end
    end

    // input register
    assign s1_ready      = !s1_valid_reg || prod_ready;
    assign point_stall   = !s1_ready;
    assign s1_valid_next = s1_ready ? point_valid : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && point_valid)
        begin
            s1_item_reg <= point;
        end
    end

    cra_product_stage u_product
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_valid_reg),
        .in_item    (s1_item_reg),
        .center_x   (center_x_reg),
        .center_y   (center_y_reg),
        .ready_down (res_ready),
        .ready_up   (prod_ready),
        .out_valid  (prod_valid),
        .out_data   (prod_data)
    );

    cra_result_stage u_result
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_data   (prod_data),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .stall     (result_stall),
        .ready_up  (res_ready),
        .out_valid (result_valid),
        .out_item  (result)
    );

`ifndef NO_ASSERTIONS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        point_stall |-> s1_valid_reg)
        else $error("input stalled with an empty input register");

    a_input_reg_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !prod_ready |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("input register lost or changed a blocked transaction");

    a_saturation_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated |->
            (result.rotated_x == COORD_MAX) || (result.rotated_x == COORD_MIN) ||
            (result.rotated_y == COORD_MAX) || (result.rotated_y == COORD_MIN))
        else $error("saturation flagged without a clamped coordinate");
`endif

endmodule
